// ===== rtl/mioc_pkg.sv =====
// ----------------------------------------------------------------------------
// mioc_pkg
// Shared constants and pipeline types of the multidimensional index / linear
// offset converter.
// ----------------------------------------------------------------------------
package mioc_pkg;

    // design limits
    localparam int MAX_DIMS   = 4;
    localparam int SIZE_LIMIT = 4096;

    // fixed field widths
    localparam int NUM_FIELDS = 4;
    localparam int OFF_W      = 48;
    localparam int IDX_W      = 16;
    localparam int KIND_W     = 2;
    localparam int SEL_W      = 2;
    localparam int DIMS_W     = 3;
    localparam int CFG_SZ_W   = 13;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;

    // derived widths and limits
    localparam int DIMS_LIM   = (MAX_DIMS < NUM_FIELDS) ? MAX_DIMS : NUM_FIELDS;
    localparam int ESZ_W      = $clog2(SIZE_LIMIT + 1);
    localparam int REM_W      = $clog2(SIZE_LIMIT);

    // divider pipeline shape: quotient bits per stage, stages per dimension
    localparam int BPS        = 4;
    localparam int STG        = OFF_W / BPS;
    localparam int DIV_STAGES = NUM_FIELDS * STG;
    localparam int TAIL_STAGES = 2 * NUM_FIELDS;
    localparam int LAT_EDGES  = DIV_STAGES + TAIL_STAGES;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_PACK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UNPACK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STRIDE = 2'd2;

    // register indexes (byte address bits [4:2])
    localparam logic [2:0] REG_DIMS  = 3'd0;
    localparam logic [2:0] REG_SIZE0 = 3'd1;
    localparam logic [2:0] REG_SIZE1 = 3'd2;
    localparam logic [2:0] REG_SIZE2 = 3'd3;
    localparam logic [2:0] REG_SIZE3 = 3'd4;

    // item state through the divider sections
    typedef struct packed {
        logic [KIND_W-1:0]                 kind;
        logic [NUM_FIELDS-1:0]             skip;
        logic [SEL_W-1:0]                  sel;
        logic [NUM_FIELDS-1:0][IDX_W-1:0]  idx;
        logic [NUM_FIELDS-1:0][IDX_W-1:0]  res;
        logic [OFF_W-1:0]                  cur_q;
        logic [OFF_W-1:0]                  wq;
        logic [REM_W-1:0]                  rem;
    } div_item_t;

    // item state through the offset / stride tail
    typedef struct packed {
        logic [KIND_W-1:0]                 kind;
        logic [SEL_W-1:0]                  sel;
        logic [NUM_FIELDS-1:0][IDX_W-1:0]  res;
        logic [OFF_W-1:0]                  acc;
        logic [OFF_W-1:0]                  stride;
        logic [OFF_W-1:0]                  prod;
    } tail_item_t;

endpackage

// ===== rtl/multidim_index_offset_converter.sv =====
// ----------------------------------------------------------------------------
// multidim_index_offset_converter
// Converts per-dimension indexes to a linear offset and back, dimension zero
// fastest, and answers stride queries.
// ----------------------------------------------------------------------------
// Usage:
//   Configure dims_in_use and size_d0..size_d3 over the APB port while idle
//   (byte addresses 0x00, 0x04 .. 0x10); pready is always high.
//   Drive start with the item fields; busy is always low, so an item is
//   taken in every cycle that start is high.
//   Each result comes out with done high for exactly one cycle; results keep
//   input order.
//   Throughput is one item per cycle. The pipeline holds one input stage,
//   a pipelined restoring divider of 12 stages of 4 quotient bits per
//   dimension over four dimensions, and 8 stages that build the offset and
//   stride, a multiply stage then an add stage per dimension.
//   Reset clears all valid bits and sets dims_in_use and the sizes to 1.
//   The receiver cannot stall the block: every result is a single-cycle
//   transfer.
// ----------------------------------------------------------------------------
module multidim_index_offset_converter
    import mioc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    // apb configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready,
    // command
    input  logic                       start,
    output logic                       busy,
    input  logic [KIND_W-1:0]          kind,
    input  logic [OFF_W-1:0]           linear_offset,
    input  logic signed [IDX_W-1:0]    index_d0,
    input  logic signed [IDX_W-1:0]    index_d1,
    input  logic signed [IDX_W-1:0]    index_d2,
    input  logic signed [IDX_W-1:0]    index_d3,
    input  logic [NUM_FIELDS-1:0]      skip_mask,
    input  logic [SEL_W-1:0]           dim_select,
    // result
    output logic                       done,
    output logic [OFF_W-1:0]           offset_out,
    output logic signed [IDX_W-1:0]    out_d0,
    output logic signed [IDX_W-1:0]    out_d1,
    output logic signed [IDX_W-1:0]    out_d2,
    output logic signed [IDX_W-1:0]    out_d3
);

    // configuration registers, raw and effective
    logic [DIMS_W-1:0]                     dims_raw_reg;
    logic [DIMS_W-1:0]                     dims_eff_reg;
    logic [NUM_FIELDS-1:0][CFG_SZ_W-1:0]   size_raw_reg;
    logic [NUM_FIELDS-1:0][ESZ_W-1:0]      size_eff_reg;

    logic                                  cfg_wr;
    logic [2:0]                            cfg_idx;
    logic [DIMS_W-1:0]                     wr_dims;
    logic [DIMS_W-1:0]                     wr_dims_eff;
    logic [CFG_SZ_W-1:0]                   wr_size;
    logic [ESZ_W-1:0]                      wr_size_eff;

    // pipeline registers
    div_item_t                             dp_reg   [DIV_STAGES+1];
    div_item_t                             dp_next  [DIV_STAGES+1];
    logic [DIV_STAGES:0]                   dv_reg;
    tail_item_t                            tp_reg   [TAIL_STAGES];
    tail_item_t                            tp_next  [TAIL_STAGES];
    logic [TAIL_STAGES-1:0]                tv_reg;
    tail_item_t                            t_last;

    // one divider stage: optional section setup, BPS restoring steps,
    // optional section finish
    function automatic div_item_t div_stage(
        input div_item_t          it,
        input logic [ESZ_W-1:0]   dv,
        input logic               first,
        input logic               last,
        input logic [1:0]         d,
        input logic [DIMS_W-1:0]  n
    );
        div_item_t          o;
        logic [IDX_W-1:0]   a;
        logic [REM_W:0]     sh;
        logic               ge;
        logic [ESZ_W-1:0]   wrapped;
        o = it;
        if (first)
        begin
            a = it.idx[d];
            if (a[IDX_W-1])
                a = ~a + 1'b1;
            o.wq  = (it.kind == KIND_PACK) ? OFF_W'(a) : it.cur_q;
            o.rem = '0;
        end
        for (int i = 0; i < BPS; i++)
        begin
            sh    = {o.rem, o.wq[OFF_W-1]};
            ge    = ({1'b0, sh} >= {1'b0, dv});
            o.wq  = {o.wq[OFF_W-2:0], ge};
            o.rem = ge ? REM_W'(sh - dv) : sh[REM_W-1:0];
        end
        if (last && (DIMS_W'(d) < n))
        begin
            if (o.kind == KIND_PACK)
            begin
                wrapped = (it.idx[d][IDX_W-1] && (o.rem != '0)) ?
                          ESZ_W'(dv - ESZ_W'(o.rem)) : ESZ_W'(o.rem);
                o.res[d] = IDX_W'(wrapped);
            end
            else if ((o.kind == KIND_UNPACK) && !o.skip[d])
            begin
                o.res[d] = IDX_W'(o.rem);
                o.cur_q  = o.wq;
            end
        end
        return o;
    endfunction

    // apb decode
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;
    assign cfg_idx     = paddr[4:2];
    assign wr_dims     = pwdata[DIMS_W-1:0];
    assign wr_dims_eff = (wr_dims == '0) ? DIMS_W'(1) :
                         ((32'(wr_dims) > 32'(DIMS_LIM)) ? DIMS_W'(DIMS_LIM) : wr_dims);
    assign wr_size     = pwdata[CFG_SZ_W-1:0];
    assign wr_size_eff = (wr_size == '0) ? ESZ_W'(1) :
                         ((32'(wr_size) > 32'(SIZE_LIMIT)) ? ESZ_W'(SIZE_LIMIT) :
                          ESZ_W'(wr_size));

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_raw_reg <= DIMS_W'(1);
            dims_eff_reg <= DIMS_W'(1);
            for (int d = 0; d < NUM_FIELDS; d++)
            begin
                size_raw_reg[d] <= CFG_SZ_W'(1);
                size_eff_reg[d] <= ESZ_W'(1);
            end
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_DIMS:
                begin
                    dims_raw_reg <= wr_dims;
                    dims_eff_reg <= wr_dims_eff;
                end
                REG_SIZE0:
                begin
                    size_raw_reg[0] <= wr_size;
                    size_eff_reg[0] <= wr_size_eff;
                end
                REG_SIZE1:
                begin
                    size_raw_reg[1] <= wr_size;
                    size_eff_reg[1] <= wr_size_eff;
                end
                REG_SIZE2:
                begin
                    size_raw_reg[2] <= wr_size;
                    size_eff_reg[2] <= wr_size_eff;
                end
                REG_SIZE3:
                begin
                    size_raw_reg[3] <= wr_size;
                    size_eff_reg[3] <= wr_size_eff;
                end
                default:
                begin
                end
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (cfg_idx)
            REG_DIMS:  prdata = PDATA_W'(dims_raw_reg);
            REG_SIZE0: prdata = PDATA_W'(size_raw_reg[0]);
            REG_SIZE1: prdata = PDATA_W'(size_raw_reg[1]);
            REG_SIZE2: prdata = PDATA_W'(size_raw_reg[2]);
            REG_SIZE3: prdata = PDATA_W'(size_raw_reg[3]);
            default:   prdata = '0;
        endcase
    end

    // the pipeline never holds off a transfer
    assign busy = 1'b0;

    // input stage and divider sections
    always_comb
    begin
        dp_next[0].kind  = kind;
        dp_next[0].skip  = skip_mask;
        dp_next[0].sel   = dim_select;
        dp_next[0].idx   = {index_d3, index_d2, index_d1, index_d0};
        dp_next[0].res   = {index_d3, index_d2, index_d1, index_d0};
        dp_next[0].cur_q = linear_offset;
        dp_next[0].wq    = '0;
        dp_next[0].rem   = '0;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            dp_next[s+1] = div_stage(dp_reg[s], size_eff_reg[s / STG],
                                     (s % STG) == 0, (s % STG) == (STG - 1),
                                     2'(s / STG), dims_eff_reg);
        end
    end

    // offset and stride tail: multiply stage then add stage per dimension
    always_comb
    begin
        tail_item_t        src;
        logic [REM_W-1:0]  r;
        logic              en;
        for (int k = 0; k < NUM_FIELDS; k++)
        begin
            if (k == 0)
            begin
                src.kind   = dp_reg[DIV_STAGES].kind;
                src.sel    = dp_reg[DIV_STAGES].sel;
                src.res    = dp_reg[DIV_STAGES].res;
                src.acc    = '0;
                src.stride = OFF_W'(1);
                src.prod   = '0;
            end
            else
                src = tp_reg[2*k-1];
            r  = ((DIMS_W'(k) < dims_eff_reg) && (src.kind == KIND_PACK)) ?
                 src.res[k][REM_W-1:0] : '0;
            en = (DIMS_W'(k) < dims_eff_reg) &&
                 ((src.kind != KIND_STRIDE) || (SEL_W'(k) < src.sel));
            tp_next[2*k]        = src;
            tp_next[2*k].prod   = OFF_W'(src.stride * OFF_W'(r));
            tp_next[2*k].stride = en ? OFF_W'(src.stride * OFF_W'(size_eff_reg[k])) :
                                  src.stride;
            tp_next[2*k+1]      = tp_reg[2*k];
            tp_next[2*k+1].acc  = OFF_W'(tp_reg[2*k].acc + tp_reg[2*k].prod);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        for (int s = 0; s <= DIV_STAGES; s++)
            dp_reg[s] <= dp_next[s];
        for (int t = 0; t < TAIL_STAGES; t++)
            tp_reg[t] <= tp_next[t];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg <= '0;
            tv_reg <= '0;
        end
        else
        begin
            dv_reg <= {dv_reg[DIV_STAGES-1:0], start && !busy};
            tv_reg <= {tv_reg[TAIL_STAGES-2:0], dv_reg[DIV_STAGES]};
        end
    end

    // result ports
    assign t_last     = tp_reg[TAIL_STAGES-1];
    assign done       = tv_reg[TAIL_STAGES-1];
    assign offset_out = (t_last.kind == KIND_PACK)   ? t_last.acc :
                        (t_last.kind == KIND_STRIDE) ? t_last.stride : '0;
    assign out_d0     = signed'(t_last.res[0]);
    assign out_d1     = signed'(t_last.res[1]);
    assign out_d2     = signed'(t_last.res[2]);
    assign out_d3     = signed'(t_last.res[3]);

    // every result traces back to an item taken a fixed number of cycles earlier
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(dv_reg[0], LAT_EDGES))
        else $error("result strobe out of step with accepted items");

    // wrapped indexes are never negative
    a_wrap_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (t_last.kind == KIND_PACK)) |-> (out_d0 >= 0))
        else $error("packed index not wrapped into range");

    // stride of dimension zero is one
    a_stride0: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (t_last.kind == KIND_STRIDE) && (t_last.sel == '0))
        |-> (offset_out == OFF_W'(1)))
        else $error("stride of dimension zero not one");

    // the first dimension is always active, so its stride multiplies in
    a_stride_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (tv_reg[0] && (tp_reg[0].kind == KIND_PACK))
        |-> (tp_reg[0].stride == OFF_W'(size_eff_reg[0])))
        else $error("stride chain skipped dimension zero");

endmodule
